>>> design/gdsa_pkg.sv
// Shared types, constants and calendar functions for the Gregorian date step core.
package gdsa_pkg;

	localparam int MAX_DAYS   = 1048575;
	localparam int DIFF_REACH = 1048575;
	localparam int DIFF_LIMIT = (MAX_DAYS < DIFF_REACH) ? MAX_DAYS : DIFF_REACH;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int OFF_W = 21;
	localparam int CNT_W = 21;

	localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

	// Multiplicative inverse of 25 modulo 2**14 and the largest product
	// that marks an exact multiple of 25.
	localparam logic [YEAR_W-1:0] INV25 = 14'd7209;
	localparam logic [YEAR_W-1:0] MUL25_MAX = 14'd655;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHK1 = 5'b00010,
		S_CHK2 = 5'b00100,
		S_CHK3 = 5'b01000,
		S_WALK = 5'b10000
	} state_t;

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;

	// A year divides by 25 exactly when its product with the inverse of 25
	// lands in the low band; that covers the century and 400-year rules.
	function automatic logic is_leap(input year_t y);
		year_t prod;
		logic  by25;
		prod = y * INV25;
		by25 = (prod <= MUL25_MAX);
		return (y[1:0] == 2'b00) && (!by25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic day_t days_in_month(input month_t m, input logic leap);
		day_t dim;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: dim = 5'd30;
			MONTH_FEB:               dim = leap ? 5'd29 : 5'd28;
			default:                 dim = 5'd31;
		endcase
		return dim;
	endfunction

	function automatic logic date_ok(input year_t y, input month_t m, input day_t d,
		input logic leap);
		return (y <= YEAR_MAX) && (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
			(d != '0) && (d <= days_in_month(m, leap));
	endfunction

endpackage

>>> design/gregorian_date_step_arithmetic_core.sv
// Gregorian date step core: date plus signed offset, or day count between two dates.
// One transaction is taken at a time and walks the calendar one day per clock cycle.
// With no day to walk, an item passes the accepting cycle and the three check states;
// otherwise the walk then steps through the days and ends in a closing cycle. The
// single day-step unit and its step counter set the length of the walk. A shared
// leap-year unit serves both dates during setup. Invalid dates, results outside
// years 0..9999 and offsets or differences beyond MAX_DAYS end the walk early
// with the error flag set and all result fields zero. s_tready is high only while
// the core is idle, a finished result waits in the output register, and a finished
// walk holds until that register is free.
module gregorian_date_step_arithmetic_core
	import gdsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// first_year[13:0], first_month[17:14], first_day[22:18], day_offset[43:23],
	// second_year[57:44], second_month[61:58], second_day[66:62], zero fill above
	input  logic [71:0] s_tdata,
	// mode[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_year[13:0], out_month[17:14], out_day[22:18], day_difference[43:23],
	// zero fill above
	output logic [47:0] m_tdata,
	// error_flag[0]
	output logic [0:0]  m_tuser
);

	state_t state_q;
	logic   mode_q;
	logic   back_q;
	logic   leap_q;
	logic   sec_leap_q;
	year_t  cur_year_q;
	month_t cur_month_q;
	day_t   cur_day_q;
	year_t  sec_year_q;
	month_t sec_month_q;
	day_t   sec_day_q;
	logic [OFF_W-1:0] off_q;
	logic [CNT_W-1:0] cnt_q;

	year_t  out_year_q;
	month_t out_month_q;
	day_t   out_day_q;
	logic [OFF_W-1:0] diff_q;
	logic   err_q;
	logic   out_valid_q;

	logic   accept;
	logic   out_free;
	logic   leap_in;
	year_t  leap_year;
	logic   first_ok;
	logic   sec_ok;
	logic   same;
	logic   sec_before;
	logic   at_top;
	logic   at_bottom;
	logic [OFF_W-1:0] off_mag;
	year_t  nxt_year;
	month_t nxt_month;
	day_t   nxt_day;
	day_t   dim_cur;
	day_t   dim_prev;

	// Set when the current state has a result; the output register takes it once free.
	logic   fin;
	logic   fin_err;
	year_t  fin_year;
	month_t fin_month;
	day_t   fin_day;
	logic [OFF_W-1:0] fin_diff;
	logic   step;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;

	// The leap-year unit looks at the second date only during the first check cycle.
	assign leap_year = (state_q == S_CHK1) ? sec_year_q : cur_year_q;
	assign leap_in   = is_leap(leap_year);

	assign first_ok = date_ok(cur_year_q, cur_month_q, cur_day_q, leap_q);
	assign sec_ok   = date_ok(sec_year_q, sec_month_q, sec_day_q, sec_leap_q);
	assign same     = {cur_year_q, cur_month_q, cur_day_q} ==
		{sec_year_q, sec_month_q, sec_day_q};
	assign sec_before = {sec_year_q, sec_month_q, sec_day_q} <
		{cur_year_q, cur_month_q, cur_day_q};
	assign at_top    = (cur_year_q == YEAR_MAX) && (cur_month_q == MONTH_DEC) &&
		(cur_day_q == DAY_LAST_DEC);
	assign at_bottom = (cur_year_q == '0) && (cur_month_q == MONTH_JAN) &&
		(cur_day_q == day_t'(1));
	assign off_mag   = off_q[OFF_W-1] ? OFF_W'(-off_q) : off_q;
	assign dim_cur   = days_in_month(cur_month_q, leap_q);
	assign dim_prev  = days_in_month(cur_month_q - MONTH_JAN, leap_q);

	// One calendar day forward or backward. The leap bit is registered from the current
	// year, so it trails a year change, which is harmless since the walk then sits in January or December.
	always_comb begin
		nxt_year  = cur_year_q;
		nxt_month = cur_month_q;
		nxt_day   = cur_day_q;
		if (!back_q) begin
			if (cur_day_q == dim_cur) begin
				nxt_day = day_t'(1);
				if (cur_month_q == MONTH_DEC) begin
					nxt_month = MONTH_JAN;
					nxt_year  = cur_year_q + year_t'(1);
				end else begin
					nxt_month = cur_month_q + month_t'(1);
				end
			end else begin
				nxt_day = cur_day_q + day_t'(1);
			end
		end else begin
			if (cur_day_q == day_t'(1)) begin
				if (cur_month_q == MONTH_JAN) begin
					nxt_month = MONTH_DEC;
					nxt_day   = DAY_LAST_DEC;
					nxt_year  = cur_year_q - year_t'(1);
				end else begin
					nxt_month = cur_month_q - month_t'(1);
					nxt_day   = dim_prev;
				end
			end else begin
				nxt_day = cur_day_q - day_t'(1);
			end
		end
	end

	always_comb begin
		fin       = 1'b0;
		fin_err   = 1'b0;
		fin_year  = '0;
		fin_month = '0;
		fin_day   = '0;
		fin_diff  = '0;
		step      = 1'b0;
		case (state_q)
			S_CHK3: begin
				if (!mode_q) begin
					if (!first_ok || (off_mag > OFF_W'(MAX_DAYS))) begin
						fin     = 1'b1;
						fin_err = 1'b1;
					end else if (off_mag == '0) begin
						fin       = 1'b1;
						fin_year  = cur_year_q;
						fin_month = cur_month_q;
						fin_day   = cur_day_q;
					end
				end else begin
					if (!first_ok || !sec_ok) begin
						fin     = 1'b1;
						fin_err = 1'b1;
					end else if (same) begin
						fin = 1'b1;
					end
				end
			end
			S_WALK: begin
				if (!mode_q) begin
					if (cnt_q == '0) begin
						fin       = 1'b1;
						fin_year  = cur_year_q;
						fin_month = cur_month_q;
						fin_day   = cur_day_q;
					end else if ((!back_q && at_top) || (back_q && at_bottom)) begin
						fin     = 1'b1;
						fin_err = 1'b1;
					end else begin
						step = 1'b1;
					end
				end else begin
					if (same) begin
						fin      = 1'b1;
						fin_diff = back_q ? OFF_W'(-cnt_q) : cnt_q;
					end else if (cnt_q == CNT_W'(DIFF_LIMIT)) begin
						fin     = 1'b1;
						fin_err = 1'b1;
					end else begin
						step = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHK1;
					end
				end
				S_CHK1: state_q <= S_CHK2;
				S_CHK2: state_q <= S_CHK3;
				S_CHK3, S_WALK: begin
					if (fin) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_WALK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the walk and the output register.
	always_ff @(posedge clk) begin
		if (state_q == S_CHK1) begin
			sec_leap_q <= leap_in;
		end else begin
			leap_q <= leap_in;
		end
		if (accept) begin
			mode_q      <= s_tuser[0];
			cur_year_q  <= s_tdata[13:0];
			cur_month_q <= s_tdata[17:14];
			cur_day_q   <= s_tdata[22:18];
			off_q       <= s_tdata[43:23];
			sec_year_q  <= s_tdata[57:44];
			sec_month_q <= s_tdata[61:58];
			sec_day_q   <= s_tdata[66:62];
		end
		if (state_q == S_CHK3) begin
			if (!mode_q) begin
				back_q <= off_q[OFF_W-1];
				cnt_q  <= off_mag;
			end else begin
				back_q <= sec_before;
				cnt_q  <= '0;
			end
		end else if (step) begin
			cur_year_q  <= nxt_year;
			cur_month_q <= nxt_month;
			cur_day_q   <= nxt_day;
			cnt_q       <= mode_q ? cnt_q + CNT_W'(1) : cnt_q - CNT_W'(1);
		end
		if (fin && out_free) begin
			out_year_q  <= fin_year;
			out_month_q <= fin_month;
			out_day_q   <= fin_day;
			diff_q      <= fin_diff;
			err_q       <= fin_err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, diff_q, out_day_q, out_month_q, out_year_q};
	assign m_tuser  = err_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("error result carries nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CHK1 && !s_tready)
		else $error("accepted transaction did not start the checks");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_CHK3 || $past(state_q) == S_WALK)
		else $error("result appeared outside a finishing state");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> cur_day_q != '0 && cur_month_q != '0 &&
			cur_month_q <= MONTH_DEC)
		else $error("walk left the calendar");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] && m_tdata[43:23] != '0 |-> m_tdata[22:0] == '0)
		else $error("difference result also carries a date");
`endif

endmodule
